/* hw/rtl/pcodec_pkg.sv */
// ----------------------------------------------------------------------------
// pcodec_pkg
// Shared types, codes and constant-divide helpers for the position report codec.
// ----------------------------------------------------------------------------
package pcodec_pkg;

	localparam int DIV_STEPS = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_EPOCH    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 1'b1;

	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	localparam logic [15:0] INTERVAL_RST = 16'd60;

	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_R = 8'h52;
	localparam logic [7:0] CHAR_0 = 8'h30;
	localparam logic [7:0] CHAR_9 = 8'h39;

	localparam logic [8:0] ID_MAX = 9'd323;
	localparam logic [6:0] SQ_MAX = 7'd99;

	typedef struct packed {
		logic        mode;
		logic        flag;
		logic [31:0] utc_w;
		logic [15:0] rep_hi;
		logic [15:0] tidx;
		logic [7:0]  c_flon;
		logic [7:0]  c_flat;
		logic [7:0]  c_slon;
		logic [7:0]  c_slat;
	} side_t;

	// floor(x/10) for x < 256
	function automatic logic [4:0] div10(input logic [7:0] x);
		logic [15:0] p;
		p = {8'd0, x} * 16'd205;
		return p[15:11];
	endfunction

	// floor(x/18) for x < 512
	function automatic logic [4:0] div18(input logic [8:0] x);
		logic [19:0] p;
		p = {11'd0, x} * 20'd911;
		return p[18:14];
	endfunction

endpackage

/* hw/rtl/pcodec_front.sv */
// ----------------------------------------------------------------------------
// pcodec_front
// Entry stage: time difference, grid locator, decode unpacking and product.
// ----------------------------------------------------------------------------
module pcodec_front #(
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                mode,
	input  logic [31:0]         utc_in,
	input  logic signed [23:0]  latitude,
	input  logic signed [24:0]  longitude,
	input  logic [31:0]         report_in,
	input  logic [31:0]         epoch,
	input  logic [15:0]         interval,
	output logic                valid_s1,
	output logic [31:0]         dq_s1,
	output pcodec_pkg::side_t   side_s1
);

	localparam int F    = ANGLE_FRAC_BITS;
	localparam int LONW = ((F + 10) > 25 ? (F + 10) : 25) + 1;
	localparam int LATW = ((F + 9) > 24 ? (F + 9) : 24) + 1;

	localparam logic signed [LONW-1:0] LON_OFF  = LONW'(180) << F;
	localparam logic signed [LONW-1:0] LON_SPAN = LONW'(360) << F;
	localparam logic signed [LATW-1:0] LAT_OFF  = LATW'(90) << F;
	localparam logic signed [LATW-1:0] LAT_SPAN = LATW'(180) << F;

	logic signed [LONW-1:0] lon_x, lon_r, lon_c;
	logic signed [LATW-1:0] lat_x, lat_r, lat_c;
	logic [LONW-1:0]        lon_u;
	logic [LATW-1:0]        lat_u;
	logic [7:0]             lon_units, lat_units;
	logic [4:0]             e_flon, e_flat;
	logic [7:0]             e_slon, e_slat;
	logic [8:0]             e_id;
	logic [6:0]             e_sq;
	logic [8:0]             d_id;
	logic [6:0]             d_sub;
	logic [4:0]             d_flon, d_slon;
	logic [8:0]             d_flat;
	logic [7:0]             d_slat;
	logic [31:0]            d_prod;
	pcodec_pkg::side_t      side_n;

	always_comb begin
		lon_x = LONW'(longitude);
		lon_r = lon_x + LON_OFF;
		if (lon_r < 0) begin
			lon_c = '0;
		end else if (lon_r >= LON_SPAN) begin
			lon_c = LON_SPAN - LONW'(1);
		end else begin
			lon_c = lon_r;
		end
		lat_x = LATW'(latitude);
		lat_r = lat_x + LAT_OFF;
		if (lat_r < 0) begin
			lat_c = '0;
		end else if (lat_r >= LAT_SPAN) begin
			lat_c = LAT_SPAN - LATW'(1);
		end else begin
			lat_c = lat_r;
		end
		lon_u     = lon_c;
		lat_u     = lat_c;
		lon_units = lon_u[F+8:F+1];
		lat_units = lat_u[F+7:F];
		e_flon    = pcodec_pkg::div10(lon_units);
		e_flat    = pcodec_pkg::div10(lat_units);
		e_slon    = lon_units - 8'({3'd0, e_flon} * 8'd10);
		e_slat    = lat_units - 8'({3'd0, e_flat} * 8'd10);
		e_id      = 9'({4'd0, e_flon} * 9'd18) + {4'd0, e_flat};
		e_sq      = 7'(e_slon * 8'd10) + e_slat[6:0];

		d_id   = report_in[31:23];
		d_sub  = report_in[22:16];
		d_flon = pcodec_pkg::div18(d_id);
		d_flat = d_id - 9'({4'd0, d_flon} * 9'd18);
		d_slon = pcodec_pkg::div10({1'b0, d_sub});
		d_slat = {1'b0, d_sub} - 8'({3'd0, d_slon} * 8'd10);
		d_prod = {16'd0, interval} * {16'd0, report_in[15:0]};

		side_n.mode = mode;
		if (mode == pcodec_pkg::MODE_DEC) begin
			side_n.flag   = (d_id > pcodec_pkg::ID_MAX) || (d_sub > pcodec_pkg::SQ_MAX);
			side_n.utc_w  = d_prod;
			side_n.rep_hi = report_in[31:16];
			side_n.tidx   = report_in[15:0];
			side_n.c_flon = pcodec_pkg::CHAR_A + {3'd0, d_flon};
			side_n.c_flat = pcodec_pkg::CHAR_A + d_flat[7:0];
			side_n.c_slon = pcodec_pkg::CHAR_0 + {3'd0, d_slon};
			side_n.c_slat = pcodec_pkg::CHAR_0 + d_slat;
		end else begin
			side_n.flag   = utc_in < epoch;
			side_n.utc_w  = utc_in;
			side_n.rep_hi = {e_id, e_sq};
			side_n.tidx   = '0;
			side_n.c_flon = pcodec_pkg::CHAR_A + {3'd0, e_flon};
			side_n.c_flat = pcodec_pkg::CHAR_A + {3'd0, e_flat};
			side_n.c_slon = pcodec_pkg::CHAR_0 + e_slon;
			side_n.c_slat = pcodec_pkg::CHAR_0 + e_slat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		dq_s1   <= utc_in - epoch;
		side_s1 <= side_n;
	end

endmodule

/* hw/rtl/pcodec_div_cell.sv */
// ----------------------------------------------------------------------------
// pcodec_div_cell
// One restoring divide step: yields one quotient bit and hands the word on.
// ----------------------------------------------------------------------------
module pcodec_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [15:0]       divisor,
	input  logic              in_valid,
	input  logic [15:0]       in_rem,
	input  logic [31:0]       in_dq,
	input  pcodec_pkg::side_t in_side,
	output logic              out_valid,
	output logic [15:0]       out_rem,
	output logic [31:0]       out_dq,
	output pcodec_pkg::side_t out_side
);

	logic [16:0] trial;
	logic [16:0] diff;
	logic        ge;

	always_comb begin
		trial = {in_rem, in_dq[31]};
		diff  = trial - {1'b0, divisor};
		ge    = trial >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_rem  <= ge ? diff[15:0] : trial[15:0];
		out_dq   <= {in_dq[30:0], ge};
		out_side <= in_side;
	end

endmodule

/* hw/rtl/position_report_codec.sv */
// ----------------------------------------------------------------------------
// position_report_codec
// Four-byte position report encoder/decoder on a 4-character grid locator.
// ----------------------------------------------------------------------------
// channel  | handshake           | payload
// ---------+---------------------+-------------------------------------------
// command  | start / busy        | mode, utc_in, latitude, longitude, report_in
// result   | done (1-cycle)      | report_out, time_index, utc_out, chars, flag
// config   | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One word per cycle; each word passes one entry stage, 32 divide
// cells (one quotient bit each) and one output register.
// busy stays low and cfg_ready stays high. Reset clears the valid chain and
// loads epoch 0, interval 60. Results are strobed on done and cannot stall.
// ----------------------------------------------------------------------------
module position_report_codec #(
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             mode,
	input  logic [31:0]                      utc_in,
	input  logic signed [23:0]               latitude,
	input  logic signed [24:0]               longitude,
	input  logic [31:0]                      report_in,
	output logic                             done,
	output logic [31:0]                      report_out,
	output logic [15:0]                      time_index,
	output logic [31:0]                      utc_out,
	output logic [7:0]                       field_lon_char,
	output logic [7:0]                       field_lat_char,
	output logic [7:0]                       square_lon_char,
	output logic [7:0]                       square_lat_char,
	output logic                             out_of_range,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pcodec_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                      cfg_data
);

	localparam int N = pcodec_pkg::DIV_STEPS;

	logic [31:0]       epoch_q;
	logic [15:0]       interval_q;
	logic              valid_c [0:N];
	logic [15:0]       rem_c   [0:N];
	logic [31:0]       dq_c    [0:N];
	pcodec_pkg::side_t side_c  [0:N];
	logic              done_q;
	logic              mode_q;
	pcodec_pkg::side_t last;
	logic [31:0]       quo;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q    <= '0;
			interval_q <= pcodec_pkg::INTERVAL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pcodec_pkg::CFG_EPOCH:    epoch_q    <= cfg_data;
				pcodec_pkg::CFG_INTERVAL: interval_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	pcodec_front #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (start && !busy),
		.mode     (mode),
		.utc_in   (utc_in),
		.latitude (latitude),
		.longitude(longitude),
		.report_in(report_in),
		.epoch    (epoch_q),
		.interval (interval_q),
		.valid_s1 (valid_c[0]),
		.dq_s1    (dq_c[0]),
		.side_s1  (side_c[0])
	);

	assign rem_c[0] = '0;

	for (genvar k = 0; k < N; k++) begin : g_cell
		pcodec_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.divisor  (interval_q),
			.in_valid (valid_c[k]),
			.in_rem   (rem_c[k]),
			.in_dq    (dq_c[k]),
			.in_side  (side_c[k]),
			.out_valid(valid_c[k+1]),
			.out_rem  (rem_c[k+1]),
			.out_dq   (dq_c[k+1]),
			.out_side (side_c[k+1])
		);
	end

	assign last = side_c[N];
	assign quo  = dq_c[N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_c[N];
		end
	end

	always_ff @(posedge clk) begin
		mode_q          <= last.mode;
		field_lon_char  <= last.c_flon;
		field_lat_char  <= last.c_flat;
		square_lon_char <= last.c_slon;
		square_lat_char <= last.c_slat;
		if (last.mode == pcodec_pkg::MODE_DEC) begin
			report_out   <= {last.rep_hi, last.tidx};
			time_index   <= last.tidx;
			utc_out      <= epoch_q + last.utc_w;
			out_of_range <= last.flag;
		end else begin
			report_out   <= {last.rep_hi, quo[15:0]};
			time_index   <= quo[15:0];
			utc_out      <= last.utc_w;
			out_of_range <= last.flag || (|quo[31:16]);
		end
	end

	assign done = done_q;

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_c[N] && interval_q != 16'd0) |-> (rem_c[N] < interval_q))
		else $error("divider remainder not below interval");

	a_enc_chars: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && mode_q == pcodec_pkg::MODE_ENC) |->
		(field_lon_char >= pcodec_pkg::CHAR_A && field_lon_char <= pcodec_pkg::CHAR_R &&
		 field_lat_char >= pcodec_pkg::CHAR_A && field_lat_char <= pcodec_pkg::CHAR_R &&
		 square_lon_char >= pcodec_pkg::CHAR_0 && square_lon_char <= pcodec_pkg::CHAR_9 &&
		 square_lat_char >= pcodec_pkg::CHAR_0 && square_lat_char <= pcodec_pkg::CHAR_9))
		else $error("encoded locator character out of range");

	a_enc_no_flag_fit: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_c[N] && last.mode == pcodec_pkg::MODE_ENC && !last.flag &&
		 interval_q != 16'd0) |-> (quo <= {16'd0, last.utc_w[31:16]} * 32'd65536 +
		 32'hFFFF))
		else $error("quotient exceeds dividend");

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for position_report_codec: drives encode and decode
// words through the command port and sets epoch and interval between phases.
// Every result strobed on done is compared field by field with an in-bench
// model of the codec. A directed set covers the corner cases first, then
// random phases run under several register settings and sender idle rates.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC        = 16;
	localparam int PHASES      = 5;
	localparam int PHASE_WORDS = 370;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;

	typedef struct {
		logic               mode;
		logic [31:0]        utc;
		logic signed [23:0] lat;
		logic signed [24:0] lon;
		logic [31:0]        rep;
	} codec_cmd_t;

	typedef struct {
		logic [31:0] report;
		logic [15:0] tidx;
		logic [31:0] utc;
		logic [7:0]  flon;
		logic [7:0]  flat;
		logic [7:0]  slon;
		logic [7:0]  slat;
		logic        flag;
	} codec_res_t;

	class report_ledger;
		logic [31:0] epoch;
		logic [15:0] interval;
		codec_res_t  awaited[$];
		int          mismatches;

		function new();
			epoch      = '0;
			interval   = pcodec_pkg::INTERVAL_RST;
			mismatches = 0;
		endfunction

		function void set_register(logic [pcodec_pkg::CFG_IDX_W-1:0] idx,
			logic [31:0] data);
			if (idx == pcodec_pkg::CFG_EPOCH)
				epoch = data;
			else
				interval = data[15:0];
		endfunction

		function longint clamp_span(longint r, longint span);
			if (r < 0)
				return 0;
			if (r >= span)
				return span - 1;
			return r;
		endfunction

		function codec_res_t codec_outcome(codec_cmd_t c);
			codec_res_t  r;
			longint      one, rlon, rlat, rem;
			logic [31:0] diff, q, prod;
			int unsigned flon, flat, slon, slat, id, sq;
			logic [15:0] grid;
			r    = '{default: '0};
			one  = longint'(1) << FRAC;
			if (c.mode == pcodec_pkg::MODE_ENC) begin
				diff   = c.utc - epoch;
				r.flag = (c.utc < epoch);
				if (interval == 16'd0) begin
					q      = '1;
					r.flag = 1'b1;
				end else begin
					q = diff / {16'd0, interval};
				end
				if (q > 32'h0000_FFFF)
					r.flag = 1'b1;
				r.tidx = q[15:0];
				rlon = clamp_span(longint'(c.lon) + 180 * one, 360 * one);
				flon = int'(rlon / (20 * one));
				rem  = rlon - longint'(flon) * 20 * one;
				slon = int'(rem / (2 * one));
				rlat = clamp_span(longint'(c.lat) + 90 * one, 180 * one);
				flat = int'(rlat / (10 * one));
				rem  = rlat - longint'(flat) * 10 * one;
				slat = int'(rem / one);
				grid = 16'(((flon * 18 + flat) << 7) + slon * 10 + slat);
				r.report = {grid, r.tidx};
				r.utc    = c.utc;
			end else begin
				r.report = c.rep;
				r.tidx   = c.rep[15:0];
				sq       = c.rep[22:16];
				id       = c.rep[31:23];
				prod     = {16'd0, interval} * {16'd0, c.rep[15:0]};
				r.utc    = epoch + prod;
				flon     = id / 18;
				flat     = id % 18;
				slon     = sq / 10;
				slat     = sq % 10;
				r.flag   = (id > pcodec_pkg::ID_MAX) || (sq > pcodec_pkg::SQ_MAX);
			end
			r.flon = 8'(flon + pcodec_pkg::CHAR_A);
			r.flat = 8'(flat + pcodec_pkg::CHAR_A);
			r.slon = 8'(slon + pcodec_pkg::CHAR_0);
			r.slat = 8'(slat + pcodec_pkg::CHAR_0);
			return r;
		endfunction

		function void note_command(codec_cmd_t c);
			awaited.push_back(codec_outcome(c));
		endfunction

		function void compare(string what, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch %s: expected %h, got %h", what, want, got);
			end
		endfunction

		function void check_result(codec_res_t got);
			codec_res_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: report %h", got.report);
				return;
			end
			want = awaited.pop_front();
			compare("report_out", want.report, got.report);
			compare("time_index", 32'(want.tidx), 32'(got.tidx));
			compare("utc_out", want.utc, got.utc);
			compare("field_lon_char", 32'(want.flon), 32'(got.flon));
			compare("field_lat_char", 32'(want.flat), 32'(got.flat));
			compare("square_lon_char", 32'(want.slon), 32'(got.slon));
			compare("square_lat_char", 32'(want.slat), 32'(got.slat));
			compare("out_of_range", 32'(want.flag), 32'(got.flag));
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic                 mode      = pcodec_pkg::MODE_ENC;
	logic [31:0]          utc_in    = '0;
	logic signed [23:0]   latitude  = '0;
	logic signed [24:0]   longitude = '0;
	logic [31:0]          report_in = '0;
	logic                 cfg_valid = 1'b0;
	logic [pcodec_pkg::CFG_IDX_W-1:0] cfg_index = pcodec_pkg::CFG_EPOCH;
	logic [31:0]          cfg_data  = '0;
	logic                 busy;
	logic                 done;
	logic                 cfg_ready;
	logic [31:0]          report_out;
	logic [15:0]          time_index;
	logic [31:0]          utc_out;
	logic [7:0]           field_lon_char;
	logic [7:0]           field_lat_char;
	logic [7:0]           square_lon_char;
	logic [7:0]           square_lat_char;
	logic                 out_of_range;

	report_ledger ledger;
	logic [31:0]  cfg_epoch    = '0;
	logic [15:0]  cfg_interval = pcodec_pkg::INTERVAL_RST;
	int           quiet        = 0;

	position_report_codec #(
		.ANGLE_FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.utc_in(utc_in),
		.latitude(latitude),
		.longitude(longitude),
		.report_in(report_in),
		.done(done),
		.report_out(report_out),
		.time_index(time_index),
		.utc_out(utc_out),
		.field_lon_char(field_lon_char),
		.field_lat_char(field_lat_char),
		.square_lon_char(square_lon_char),
		.square_lat_char(square_lat_char),
		.out_of_range(out_of_range),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy)
			ledger.note_command('{mode, utc_in, latitude, longitude, report_in});
		if (arst_n && done)
			ledger.check_result('{report_out, time_index, utc_out, field_lon_char,
				field_lat_char, square_lon_char, square_lat_char, out_of_range});
		if (arst_n && cfg_valid && cfg_ready)
			ledger.set_register(cfg_index, cfg_data);
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic issue(codec_cmd_t c);
		start     <= 1'b1;
		mode      <= c.mode;
		utc_in    <= c.utc;
		latitude  <= c.lat;
		longitude <= c.lon;
		report_in <= c.rep;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (ledger.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [pcodec_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic set_config(logic [31:0] e, logic [15:0] iv);
		write_reg(pcodec_pkg::CFG_EPOCH, e);
		write_reg(pcodec_pkg::CFG_INTERVAL, {16'd0, iv});
		cfg_valid    <= 1'b0;
		cfg_epoch    = e;
		cfg_interval = iv;
	endtask

	function automatic codec_cmd_t enc_cmd(logic [31:0] u, int la, int lo);
		codec_cmd_t c;
		c.mode = pcodec_pkg::MODE_ENC;
		c.utc  = u;
		c.lat  = 24'(la);
		c.lon  = 25'(lo);
		c.rep  = $urandom;
		return c;
	endfunction

	function automatic codec_cmd_t dec_cmd(logic [31:0] r);
		codec_cmd_t c;
		c.mode = pcodec_pkg::MODE_DEC;
		c.utc  = $urandom;
		c.lat  = 24'($urandom);
		c.lon  = 25'($urandom);
		c.rep  = r;
		return c;
	endfunction

	function automatic int pick_angle(int span);
		case ($urandom_range(0, 19))
			0:       return -span;
			1:       return span;
			2:       return int'($urandom);
			default: return int'($urandom_range(0, 2 * span)) - span;
		endcase
	endfunction

	function automatic codec_cmd_t random_cmd();
		logic [31:0] u, off;
		int          pick;
		if ($urandom_range(0, 1) == 0) begin
			pick = $urandom_range(0, 99);
			off  = (cfg_interval == 16'd0) ? $urandom : $urandom_range(0, cfg_interval - 1);
			if (pick < 60)
				u = cfg_epoch + cfg_interval * $urandom_range(0, 65535) + off;
			else if (pick < 70)
				u = cfg_epoch + cfg_interval * (32'd65535 + $urandom_range(0, 1)) + off;
			else if (pick < 80)
				u = cfg_epoch - $urandom_range(1, 5000);
			else if (pick < 85)
				u = cfg_epoch;
			else
				u = $urandom;
			return enc_cmd(u, pick_angle(90 << FRAC), pick_angle(180 << FRAC));
		end
		if ($urandom_range(0, 9) < 7)
			return dec_cmd({9'($urandom_range(0, 323)), 7'($urandom_range(0, 99)),
				16'($urandom)});
		return dec_cmd($urandom);
	endfunction

	initial begin
		codec_cmd_t  directed[$];
		logic [31:0] ph_epoch [PHASES];
		logic [15:0] ph_interval [PHASES];
		int          ph_idle [PHASES];
		logic [31:0] e0;
		ledger = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		e0 = 32'd1_000_000;
		set_config(e0, 16'd60);
		directed.push_back(enc_cmd(e0, 0, 0));
		directed.push_back(enc_cmd(e0 - 1, 0, 0));
		directed.push_back(enc_cmd(e0 + 60 * 65535 + 59, 1 << FRAC, 1 << FRAC));
		directed.push_back(enc_cmd(e0 + 60 * 65536, -(1 << FRAC), -(1 << FRAC)));
		directed.push_back(enc_cmd(32'hFFFF_FFFF, -(90 << FRAC), -(180 << FRAC)));
		directed.push_back(enc_cmd(e0 + 123, 90 << FRAC, 180 << FRAC));
		directed.push_back(enc_cmd(e0 + 456, (90 << FRAC) - 1, (180 << FRAC) - 1));
		directed.push_back(enc_cmd(e0 + 789, -8388608, -16777216));
		directed.push_back(enc_cmd(e0 + 999, 8388607, 16777215));
		directed.push_back(enc_cmd(e0 + 60, -1, -1));
		directed.push_back(enc_cmd(32'd0, 32'h0040_0000, 32'h0080_0000));
		directed.push_back(dec_cmd(32'h0000_0000));
		directed.push_back(dec_cmd(32'hFFFF_FFFF));
		directed.push_back(dec_cmd({9'd323, 7'd99, 16'hFFFF}));
		directed.push_back(dec_cmd({9'd324, 7'd0, 16'h0001}));
		directed.push_back(dec_cmd({9'd0, 7'd100, 16'h8000}));
		directed.push_back(dec_cmd({9'd306, 7'd9, 16'h0001}));
		foreach (directed[i])
			issue(directed[i]);
		drain();

		// zero interval
		set_config(32'd5555, 16'd0);
		issue(enc_cmd(32'd5555, 0, 0));
		issue(enc_cmd(32'd12345, 45 << FRAC, -(90 << FRAC)));
		issue(dec_cmd({9'd100, 7'd50, 16'd1234}));
		issue(dec_cmd($urandom));
		drain();

		ph_epoch    = '{32'd0, 32'hFFFF_FFFF, $urandom, $urandom, $urandom};
		ph_interval = '{16'd1, 16'hFFFF, 16'($urandom_range(1, 65535)),
			pcodec_pkg::INTERVAL_RST, 16'($urandom_range(2, 300))};
		ph_idle     = '{0, 79, 0, 38, 79};
		for (int p = 0; p < PHASES; p++) begin
			set_config(ph_epoch[p], ph_interval[p]);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				while ($urandom_range(0, 99) < ph_idle[p]) begin
					start <= 1'b0;
					@(posedge clk);
				end
				issue(random_cmd());
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (ledger.mismatches == 0 && ledger.outstanding() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/pcodec_pkg.sv
hw/rtl/pcodec_front.sv
hw/rtl/pcodec_div_cell.sv
hw/rtl/position_report_codec.sv
tb/sv/testbench.sv
